@@ rtl/text_escape_newline_normalizer_assert.svh @@
// Assertion macros for the text escape and newline normalizer.
// Expects clk and rst in the scope of each use.
`ifndef TEXT_ESCAPE_NEWLINE_NORMALIZER_ASSERT_SVH
`define TEXT_ESCAPE_NEWLINE_NORMALIZER_ASSERT_SVH

// Same-cycle implication.
`define TENN_ASSERT_IMPLIES(name, lhs, rhs) \
  name: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error("tenn: same-cycle check failed");

// Next-cycle implication.
`define TENN_ASSERT_NEXT(name, lhs, rhs) \
  name: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error("tenn: next-cycle check failed");

`endif

@@ rtl/tenn_pkg.sv @@
// Shared constants, types and the hex digit decoder of the text normalizer.
// No dependencies.
package tenn_pkg;

  localparam int UnitWidth  = 16;
  localparam int EscLen     = 5;
  localparam int SeqLen     = EscLen + 1;
  localparam int CountWidth = $clog2(EscLen + 1);
  localparam int SlotCount  = 2 * SeqLen + 2;
  localparam int FlushSlot  = 2 * SeqLen;
  localparam int EmptySlot  = 2 * SeqLen + 1;
  localparam int HexLetterBase = 10;

  typedef logic [UnitWidth-1:0]  unit_t;
  typedef logic [CountWidth-1:0] count_t;
  typedef logic [SlotCount-1:0]  slot_mask_t;

  localparam unit_t ChBackslash = unit_t'(8'h5C);
  localparam unit_t ChU         = unit_t'(8'h75);
  localparam unit_t ChN         = unit_t'(8'h6E);
  localparam unit_t ChR         = unit_t'(8'h72);
  localparam unit_t ChCr        = unit_t'(8'h0D);
  localparam unit_t ChLf        = unit_t'(8'h0A);
  localparam unit_t ChDigit0    = unit_t'(8'h30);
  localparam unit_t ChDigit9    = unit_t'(8'h39);
  localparam unit_t ChLowerA    = unit_t'(8'h61);
  localparam unit_t ChLowerF    = unit_t'(8'h66);
  localparam unit_t ChUpperA    = unit_t'(8'h41);
  localparam unit_t ChUpperF    = unit_t'(8'h46);

  typedef struct packed {
    unit_t code_unit;
    logic  end_of_text;
  } item_t;

  typedef struct packed {
    slot_mask_t                mask;
    logic [SlotCount-1:0][UnitWidth-1:0] units;
    logic                      last;
  } bundle_t;

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_value(unit_t c);
    logic [4:0] r;
    r = '0;
    if (c >= ChDigit0 && c <= ChDigit9) begin
      r = {1'b1, c[3:0]};
    end else if (c >= ChLowerA && c <= ChLowerF) begin
      r = {1'b1, 4'(c - ChLowerA) + 4'(HexLetterBase)};
    end else if (c >= ChUpperA && c <= ChUpperF) begin
      r = {1'b1, 4'(c - ChUpperA) + 4'(HexLetterBase)};
    end
    return r;
  endfunction

endpackage

@@ rtl/tenn_if.sv @@
// Valid/ready channel interfaces for text code units and normalized results.
// Depends on tenn_pkg.
interface tenn_unit_if;
  logic                   valid;
  logic                   ready;
  logic [tenn_pkg::UnitWidth-1:0] code_unit;
  logic                   end_of_text;
  modport source (output valid, code_unit, end_of_text, input ready);
  modport sink (input valid, code_unit, end_of_text, output ready);
endinterface

interface tenn_result_if;
  logic                   valid;
  logic                   ready;
  logic [tenn_pkg::UnitWidth-1:0] out_unit;
  logic                   has_unit;
  logic                   last_result;
  modport source (output valid, out_unit, has_unit, last_result, input ready);
  modport sink (input valid, out_unit, has_unit, last_result, output ready);
endinterface

@@ rtl/tenn_in_reg.sv @@
// Input register of the text normalizer: holds one request for the decoder.
// Depends on tenn_pkg and tenn_unit_if.
module tenn_in_reg (
  input  logic            clk,
  input  logic            rst,
  tenn_unit_if.sink       units,
  input  logic            take,
  output tenn_pkg::item_t item,
  output logic            item_valid
);

  logic valid;

  assign units.ready = !valid || take;
  assign item_valid  = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (units.ready) begin
      valid <= units.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (units.valid && units.ready) begin
      item <= '{code_unit: units.code_unit, end_of_text: units.end_of_text};
    end
  end

endmodule

@@ rtl/tenn_decode.sv @@
// Escape decoder, escaped-newline and CR/LF stages of the text normalizer.
// Holds the scan state; turns one request into a bundle of result slots.
// Depends on tenn_pkg.
module tenn_decode (
  input  logic              clk,
  input  logic              rst,
  input  tenn_pkg::item_t   item,
  input  logic              item_valid,
  input  logic              can_load,
  output logic              take,
  output logic              load,
  output tenn_pkg::bundle_t fill
);

  typedef struct packed {
    logic            emit;
    logic            acr;
    tenn_pkg::unit_t unit;
  } s3_t;

  tenn_pkg::unit_t  escape_buffer [tenn_pkg::EscLen];
  tenn_pkg::count_t escape_count;
  logic             pending_backslash;
  logic             after_escaped_cr;
  logic             after_carriage_return;

  logic             pending_backslash_next;
  logic             after_escaped_cr_next;
  logic             after_carriage_return_next;
  tenn_pkg::count_t escape_count_next;
  logic             ext_ok;
  logic             decode;

  function automatic s3_t stage_three(logic acr, tenn_pkg::unit_t y);
    s3_t r;
    r.emit = !(acr && y == tenn_pkg::ChLf);
    r.acr  = r.emit && (y == tenn_pkg::ChCr);
    r.unit = (y == tenn_pkg::ChCr) ? tenn_pkg::ChLf : y;
    return r;
  endfunction

  always_comb begin
    logic [4:0]      hx;
    logic [4:0]      h2;
    logic [4:0]      h3;
    logic [4:0]      h4;
    logic            last;
    logic            held_out;
    logic            x_out;
    tenn_pkg::unit_t x;
    tenn_pkg::unit_t s [tenn_pkg::SeqLen];
    logic [tenn_pkg::SeqLen-1:0] sv;
    logic            pb;
    logic            aec;
    logic            acr;
    logic            skip;
    logic            a_v;
    logic            b_v;
    tenn_pkg::unit_t a_val;
    tenn_pkg::unit_t b_val;
    s3_t             r;

    x    = item.code_unit;
    last = item.end_of_text;
    hx   = tenn_pkg::hex_value(x);
    h2   = tenn_pkg::hex_value(escape_buffer[2]);
    h3   = tenn_pkg::hex_value(escape_buffer[3]);
    h4   = tenn_pkg::hex_value(escape_buffer[4]);

    unique case (escape_count)
      tenn_pkg::count_t'(0): ext_ok = (x == tenn_pkg::ChBackslash);
      tenn_pkg::count_t'(1): ext_ok = (x == tenn_pkg::ChU);
      default:               ext_ok = hx[4];
    endcase
    decode = ext_ok && (escape_count == tenn_pkg::count_t'(tenn_pkg::EscLen));

    // Held prefix goes out on a mismatch or at end of text.
    held_out = last || !ext_ok;
    x_out    = last || (!ext_ok && x != tenn_pkg::ChBackslash);
    for (int i = 0; i < tenn_pkg::EscLen; i++) begin
      s[i]  = (tenn_pkg::count_t'(i) < escape_count) ? escape_buffer[i] : x;
      sv[i] = ((tenn_pkg::count_t'(i) < escape_count) && held_out)
              || ((tenn_pkg::count_t'(i) == escape_count) && x_out);
    end
    s[tenn_pkg::EscLen]  = x;
    sv[tenn_pkg::EscLen] = (escape_count == tenn_pkg::count_t'(tenn_pkg::EscLen)) && x_out;
    if (decode) begin
      s[0] = tenn_pkg::unit_t'({h2[3:0], h3[3:0], h4[3:0], hx[3:0]});
      sv   = tenn_pkg::SeqLen'(1);
    end

    escape_count_next = '0;
    if (!decode && !last) begin
      if (ext_ok) begin
        escape_count_next = escape_count + tenn_pkg::count_t'(1);
      end else if (x == tenn_pkg::ChBackslash) begin
        escape_count_next = tenn_pkg::count_t'(1);
      end
    end

    pb        = pending_backslash;
    aec       = after_escaped_cr;
    acr       = after_carriage_return;
    fill.mask = '0;
    fill.units = '0;
    fill.last = last;
    for (int i = 0; i < tenn_pkg::SeqLen; i++) begin
      skip  = 1'b0;
      a_v   = 1'b0;
      b_v   = 1'b0;
      a_val = tenn_pkg::ChBackslash;
      b_val = s[i];
      if (sv[i]) begin
        if (aec) begin
          aec  = 1'b0;
          skip = (s[i] == tenn_pkg::ChN);
        end
        if (!skip && pb) begin
          pb  = 1'b0;
          a_v = 1'b1;
          if (s[i] == tenn_pkg::ChN) begin
            a_val = tenn_pkg::ChLf;
            skip  = 1'b1;
          end else if (s[i] == tenn_pkg::ChR) begin
            a_val = tenn_pkg::ChLf;
            aec   = 1'b1;
            skip  = 1'b1;
          end
        end
        if (!skip) begin
          if (s[i] == tenn_pkg::ChBackslash) begin
            pb = 1'b1;
          end else begin
            b_v = 1'b1;
          end
        end
      end
      if (a_v) begin
        r = stage_three(acr, a_val);
        acr = r.acr;
        fill.mask[2*i]  = r.emit;
        fill.units[2*i] = r.unit;
      end
      if (b_v) begin
        r = stage_three(acr, b_val);
        acr = r.acr;
        fill.mask[2*i+1]  = r.emit;
        fill.units[2*i+1] = r.unit;
      end
    end

    // Flush a held backslash at end of text.
    if (last && pb) begin
      r = stage_three(acr, tenn_pkg::ChBackslash);
      fill.mask[tenn_pkg::FlushSlot]  = r.emit;
      fill.units[tenn_pkg::FlushSlot] = r.unit;
    end
    fill.mask[tenn_pkg::EmptySlot] = last && (fill.mask == '0);

    pending_backslash_next     = pb && !last;
    after_escaped_cr_next      = aec && !last;
    after_carriage_return_next = acr && !last;

    take = item_valid && (can_load || fill.mask == '0);
    load = take && (fill.mask != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_count          <= '0;
      pending_backslash     <= 1'b0;
      after_escaped_cr      <= 1'b0;
      after_carriage_return <= 1'b0;
    end else if (take) begin
      escape_count          <= escape_count_next;
      pending_backslash     <= pending_backslash_next;
      after_escaped_cr      <= after_escaped_cr_next;
      after_carriage_return <= after_carriage_return_next;
    end
  end

  // Append to the escape prefix, or restart it on a fresh backslash.
  always_ff @(posedge clk) begin
    if (take && !decode && !item.end_of_text) begin
      if (ext_ok) begin
        escape_buffer[escape_count] <= item.code_unit;
      end else if (item.code_unit == tenn_pkg::ChBackslash) begin
        escape_buffer[0] <= item.code_unit;
      end
    end
  end

endmodule

@@ rtl/tenn_bundle.sv @@
// Result register of the text normalizer: holds one bundle of result slots
// and sends them out lowest slot first. Depends on tenn_pkg and tenn_result_if.
module tenn_bundle (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  tenn_pkg::bundle_t fill,
  output logic              can_load,
  tenn_result_if.source     results
);

  tenn_pkg::slot_mask_t mask;
  logic [tenn_pkg::SlotCount-1:0][tenn_pkg::UnitWidth-1:0] units;
  logic                 last;

  tenn_pkg::slot_mask_t sel_hot;
  tenn_pkg::slot_mask_t rest;
  tenn_pkg::unit_t      sel_unit;

  always_comb begin
    sel_hot  = mask & (~mask + tenn_pkg::slot_mask_t'(1));
    rest     = mask & ~sel_hot;
    sel_unit = '0;
    for (int i = 0; i < tenn_pkg::SlotCount; i++) begin
      if (sel_hot[i]) begin
        sel_unit = sel_unit | units[i];
      end
    end
  end

  assign results.valid       = (mask != '0);
  assign results.out_unit    = sel_unit;
  assign results.has_unit    = !sel_hot[tenn_pkg::EmptySlot];
  assign results.last_result = last && (rest == '0);
  assign can_load            = (rest == '0) && ((mask == '0) || results.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= fill.mask;
    end else if (results.valid && results.ready) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      units <= fill.units;
      last  <= fill.last;
    end
  end

endmodule

@@ rtl/text_escape_newline_normalizer.sv @@
// Top level of the text escape decoder and newline normalizer.
// Depends on tenn_pkg, tenn_if, tenn_in_reg, tenn_decode, tenn_bundle and the assertion header.
//
// Each request carries one 16-bit code unit; backslash-u with four hex digits
// becomes one unit, escaped n and r become LF, and CR, CR-LF become one LF.
// A request passes the input register, is decoded combinationally and lands in a
// result register as a bundle of up to seven results, sent one per cycle while
// the receiver is ready. Sustained rate is one request per cycle while each
// request yields at most one result and the receiver is ready; a request that
// yields several results holds the result register until all are sent. Requests
// that yield nothing pass even while results drain. The request flagged
// end_of_text always yields at least one result, the last one marked
// last_result; if nothing is left it is an empty result with has_unit low.
`include "text_escape_newline_normalizer_assert.svh"

module text_escape_newline_normalizer (
  input  logic          clk,
  input  logic          rst,
  tenn_unit_if.sink     units,
  tenn_result_if.source results
);

  tenn_pkg::item_t   item;
  logic              item_valid;
  logic              take;
  logic              load;
  logic              can_load;
  tenn_pkg::bundle_t fill;

  tenn_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .units      (units),
    .take       (take),
    .item       (item),
    .item_valid (item_valid)
  );

  tenn_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .can_load   (can_load),
    .take       (take),
    .load       (load),
    .fill       (fill)
  );

  tenn_bundle u_bundle (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .fill     (fill),
    .can_load (can_load),
    .results  (results)
  );

  `TENN_ASSERT_IMPLIES(a_load_when_free, load, can_load)
  `TENN_ASSERT_IMPLIES(a_end_loads, take && item.end_of_text, load)
  `TENN_ASSERT_NEXT(a_load_shows, load, results.valid)
  `TENN_ASSERT_IMPLIES(a_empty_is_last, results.valid && !results.has_unit, results.last_result)

endmodule

@@ dv/text_normalizer_checker.sv @@
// Checker for the text escape and newline normalizer: watches both channels,
// predicts the normalized results of every request and compares them in order.
// Depends on tenn_pkg and the tenn_unit_if / tenn_result_if interfaces.
module text_normalizer_checker (
  input  logic   clk,
  input  logic   rst,
  tenn_unit_if   units,
  tenn_result_if results,
  output int     failures,
  output int     pending,
  output int     results_checked,
  output int     empty_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    tenn_pkg::unit_t unit;
    logic            has_unit;
    logic            last;
  } normalized_t;

  typedef tenn_pkg::unit_t escape_seq_t [tenn_pkg::SeqLen];

  normalized_t     normalized_q[$];
  tenn_pkg::unit_t escape_held[tenn_pkg::EscLen];
  int              escape_len = 0;
  logic            backslash_held = 1'b0;
  logic            swallow_n = 1'b0;
  logic            drop_lf = 1'b0;
  int              fail_total = 0;
  int              checked_total = 0;
  int              empty_total = 0;
  normalized_t     got;
  normalized_t     want;

  task automatic report_mismatch(string what);
    fail_total++;
    if (fail_total <= 20) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  function automatic int hex_digit(tenn_pkg::unit_t c);
    if (c >= tenn_pkg::ChDigit0 && c <= tenn_pkg::ChDigit9) return int'(c - tenn_pkg::ChDigit0);
    if (c >= tenn_pkg::ChLowerA && c <= tenn_pkg::ChLowerF) return int'(c - tenn_pkg::ChLowerA) + 10;
    if (c >= tenn_pkg::ChUpperA && c <= tenn_pkg::ChUpperF) return int'(c - tenn_pkg::ChUpperA) + 10;
    return -1;
  endfunction

  function automatic void queue_result(normalized_t r);
    normalized_q.insert(normalized_q.size(), r);
  endfunction

  function automatic void emit_unit(tenn_pkg::unit_t u);
    normalized_t r;
    r.unit = u;
    r.has_unit = 1'b1;
    r.last = 1'b0;
    queue_result(r);
  endfunction

  // CR becomes LF; an LF right after such a CR is dropped.
  function automatic void fold_line_end(tenn_pkg::unit_t x);
    if (drop_lf && x == tenn_pkg::ChLf) begin
      drop_lf = 1'b0;
      return;
    end
    drop_lf = 1'b0;
    if (x == tenn_pkg::ChCr) begin
      emit_unit(tenn_pkg::ChLf);
      drop_lf = 1'b1;
    end else begin
      emit_unit(x);
    end
  endfunction

  function automatic void resolve_escaped_newline(tenn_pkg::unit_t x);
    if (swallow_n) begin
      swallow_n = 1'b0;
      if (x == tenn_pkg::ChN) return;
    end
    if (backslash_held) begin
      backslash_held = 1'b0;
      if (x == tenn_pkg::ChN) begin
        fold_line_end(tenn_pkg::ChLf);
        return;
      end
      if (x == tenn_pkg::ChR) begin
        fold_line_end(tenn_pkg::ChLf);
        swallow_n = 1'b1;
        return;
      end
      fold_line_end(tenn_pkg::ChBackslash);
    end
    if (x == tenn_pkg::ChBackslash) begin
      backslash_held = 1'b1;
    end else begin
      fold_line_end(x);
    end
  endfunction

  function automatic bit escape_prefix_ok(escape_seq_t s, int n);
    if (n == 0) return 1'b1;
    if (s[0] != tenn_pkg::ChBackslash) return 1'b0;
    if (n >= 2 && s[1] != tenn_pkg::ChU) return 1'b0;
    for (int k = 2; k < n; k++) begin
      if (hex_digit(s[k]) < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void decode_unicode_escape(tenn_pkg::unit_t x);
    escape_seq_t     s;
    int              n;
    tenn_pkg::unit_t value;
    n = escape_len;
    for (int k = 0; k < n; k++) s[k] = escape_held[k];
    s[n] = x;
    n++;
    while (n > 0 && !escape_prefix_ok(s, n)) begin
      resolve_escaped_newline(s[0]);
      for (int k = 1; k < n; k++) s[k-1] = s[k];
      n--;
    end
    if (n == tenn_pkg::SeqLen) begin
      value = tenn_pkg::unit_t'((hex_digit(s[2]) << 12) | (hex_digit(s[3]) << 8) |
                                (hex_digit(s[4]) << 4) | hex_digit(s[5]));
      resolve_escaped_newline(value);
      n = 0;
    end
    for (int k = 0; k < n; k++) escape_held[k] = s[k];
    escape_len = n;
  endfunction

  function automatic void normalize_request(tenn_pkg::unit_t x, logic eot);
    int          base;
    normalized_t closing;
    base = normalized_q.size();
    decode_unicode_escape(x);
    if (eot) begin
      for (int k = 0; k < escape_len; k++) resolve_escaped_newline(escape_held[k]);
      escape_len = 0;
      if (backslash_held) begin
        backslash_held = 1'b0;
        fold_line_end(tenn_pkg::ChBackslash);
      end
      swallow_n = 1'b0;
      drop_lf = 1'b0;
      if (normalized_q.size() == base) begin
        closing = '0;
        closing.last = 1'b1;
        queue_result(closing);
      end else begin
        normalized_q[normalized_q.size()-1].last = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      normalized_q.delete();
      escape_len = 0;
      backslash_held = 1'b0;
      swallow_n = 1'b0;
      drop_lf = 1'b0;
    end else begin
      if (results.valid && results.ready) begin
        got.unit = results.out_unit;
        got.has_unit = results.has_unit;
        got.last = results.last_result;
        checked_total++;
        if (got.has_unit === 1'b0) empty_total++;
        if (normalized_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result unit %h has_unit %b last %b",
                                    got.unit, got.has_unit, got.last));
        end else begin
          want = normalized_q.pop_front();
          if (got.unit !== want.unit) begin
            report_mismatch($sformatf("out_unit %h, predicted %h", got.unit, want.unit));
          end
          if (got.has_unit !== want.has_unit) begin
            report_mismatch($sformatf("has_unit %b, predicted %b",
                                      got.has_unit, want.has_unit));
          end
          if (got.last !== want.last) begin
            report_mismatch($sformatf("last_result %b, predicted %b", got.last, want.last));
          end
        end
      end
      if (units.valid && units.ready) begin
        normalize_request(units.code_unit, units.end_of_text);
      end
    end
    failures <= fail_total;
    pending <= normalized_q.size();
    results_checked <= checked_total;
    empty_results <= empty_total;
  end

endmodule

@@ dv/tb_text_escape_newline_normalizer.sv @@
// Testbench top for the text escape and newline normalizer: clock, reset,
// request stimulus, result pacing, watchdog and verdict.
// Depends on tenn_pkg, tenn_if, the block and text_normalizer_checker.
module tb_text_escape_newline_normalizer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PaceFree,
    PaceSenderIdle,
    PaceReceiverStall,
    PaceBothIdle
  } pace_t;

  localparam int HoldOffCycles  = 300;
  localparam int StallLimit     = 2000;
  localparam int DrainCycles    = 16;
  localparam int TotalRequests  = 210;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  pace_t           pace = PaceFree;
  bit              hold_off_req = 1'b0;
  bit              hold_off_done = 1'b0;
  int              requests_sent = 0;
  int              texts_sent = 0;
  int              stall_cycles = 0;
  int              failures;
  int              pending;
  int              results_checked;
  int              empty_results;
  tenn_pkg::unit_t text_q[$];
  string           bad_chars = "Gz/:@g[ ";
  string           literal_chars = "\\nru";

  tenn_unit_if   units_ch ();
  tenn_result_if results_ch ();

  text_escape_newline_normalizer i_dut (
    .clk     (clk),
    .rst     (rst),
    .units   (units_ch),
    .results (results_ch)
  );

  text_normalizer_checker i_checker (
    .clk             (clk),
    .rst             (rst),
    .units           (units_ch),
    .results         (results_ch),
    .failures        (failures),
    .pending         (pending),
    .results_checked (results_checked),
    .empty_results   (empty_results)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit idles(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int sender_pct();
    case (pace)
      PaceSenderIdle: return 64;
      PaceBothIdle:   return 7;
      default:        return 0;
    endcase
  endfunction

  function automatic int receiver_pct();
    case (pace)
      PaceReceiverStall: return 64;
      PaceBothIdle:      return 7;
      default:           return 0;
    endcase
  endfunction

  function automatic void add_unit(tenn_pkg::unit_t u);
    text_q.insert(text_q.size(), u);
  endfunction

  function automatic void push_str(string s);
    for (int k = 0; k < s.len(); k++) add_unit(tenn_pkg::unit_t'(s[k]));
  endfunction

  function automatic void push_hex(logic [3:0] nib);
    if (nib < 10) begin
      add_unit(tenn_pkg::ChDigit0 + tenn_pkg::unit_t'(nib));
    end else if ($urandom_range(1)) begin
      add_unit(tenn_pkg::ChUpperA + tenn_pkg::unit_t'(nib - 10));
    end else begin
      add_unit(tenn_pkg::ChLowerA + tenn_pkg::unit_t'(nib - 10));
    end
  endfunction

  function automatic void push_escape();
    tenn_pkg::unit_t v;
    case ($urandom_range(7))
      0:       v = tenn_pkg::ChBackslash;
      1:       v = tenn_pkg::ChCr;
      2:       v = tenn_pkg::ChLf;
      3:       v = tenn_pkg::ChN;
      4:       v = tenn_pkg::ChR;
      default: v = tenn_pkg::unit_t'($urandom);
    endcase
    add_unit(tenn_pkg::ChBackslash);
    add_unit(tenn_pkg::ChU);
    push_hex(v[15:12]);
    push_hex(v[11:8]);
    push_hex(v[7:4]);
    push_hex(v[3:0]);
  endfunction

  // Cut an escape short, then usually break it with a non-hex unit.
  function automatic void push_broken_escape();
    int digits;
    digits = $urandom_range(4);
    add_unit(tenn_pkg::ChBackslash);
    if (digits > 0) begin
      add_unit(tenn_pkg::ChU);
      for (int k = 1; k < digits; k++) push_hex(4'($urandom));
    end
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(3) == 0) begin
        add_unit(tenn_pkg::unit_t'($urandom));
      end else begin
        add_unit(tenn_pkg::unit_t'(bad_chars[$urandom_range(bad_chars.len() - 1)]));
      end
    end
  endfunction

  function automatic void push_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30) begin
      push_escape();
    end else if (pick < 42) begin
      push_broken_escape();
    end else if (pick < 50) begin
      push_str("\\n");
    end else if (pick < 58) begin
      push_str("\\r");
      if ($urandom_range(1)) push_str("n");
    end else if (pick < 66) begin
      add_unit(tenn_pkg::ChCr);
    end else if (pick < 72) begin
      add_unit(tenn_pkg::ChLf);
    end else if (pick < 80) begin
      add_unit(tenn_pkg::unit_t'(literal_chars[$urandom_range(3)]));
    end else begin
      add_unit(tenn_pkg::unit_t'($urandom));
    end
  endfunction

  task automatic send_request(tenn_pkg::unit_t u, logic eot);
    while (idles(sender_pct())) begin
      units_ch.valid <= 1'b0;
      @(posedge clk);
    end
    units_ch.valid <= 1'b1;
    units_ch.code_unit <= u;
    units_ch.end_of_text <= eot;
    do @(posedge clk); while (!units_ch.ready);
    requests_sent++;
  endtask

  task automatic send_text();
    for (int k = 0; k < text_q.size(); k++) begin
      send_request(text_q[k], k == text_q.size() - 1);
    end
    text_q.delete();
    texts_sent++;
  endtask

  initial begin
    results_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_done) begin
        results_ch.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_done = 1'b1;
      end
      results_ch.ready <= !idles(receiver_pct());
    end
  end

  initial begin
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if (rst || (units_ch.valid && units_ch.ready) ||
          (results_ch.valid && results_ch.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("watchdog: no handshake for %0d cycles, %0d results owed", StallLimit, pending);
    $display("FAIL text_escape_newline_normalizer");
    $finish;
  end

  initial begin
    units_ch.valid = 1'b0;
    units_ch.code_unit = '0;
    units_ch.end_of_text = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    add_unit(tenn_pkg::unit_t'(0));
    add_unit(tenn_pkg::unit_t'(16'hFFFF));
    push_str("\\uaF09");
    push_str("\\u1G");
    push_str("\\n");
    push_str("\\rn");
    add_unit(tenn_pkg::ChCr);
    add_unit(tenn_pkg::ChLf);
    add_unit(tenn_pkg::ChBackslash);
    send_text();
    add_unit(tenn_pkg::ChCr);
    add_unit(tenn_pkg::ChLf);
    send_text();
    push_str("\\u1");
    send_text();

    hold_off_req = 1'b1;
    while (requests_sent < TotalRequests) begin
      if (!hold_off_done) begin
        pace = PaceFree;
      end else begin
        pace = pace_t'(2'((texts_sent / 3) % 4));
      end
      repeat ($urandom_range(1, 6)) push_token();
      send_text();
    end
    units_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d code units in %0d texts: hex escapes, escaped and bare newlines,",
             requests_sent, texts_sent);
    $display("broken and cut-off escapes; %0d results checked, %0d empty closing results.",
             results_checked, empty_results);
    if (failures == 0) begin
      $display("PASS text_escape_newline_normalizer");
    end else begin
      $display("FAIL text_escape_newline_normalizer");
    end
    $finish;
  end

endmodule

@@ text_escape_newline_normalizer.f @@
+incdir+rtl
rtl/tenn_pkg.sv
rtl/tenn_if.sv
rtl/tenn_in_reg.sv
rtl/tenn_decode.sv
rtl/tenn_bundle.sv
rtl/text_escape_newline_normalizer.sv
dv/text_normalizer_checker.sv
dv/tb_text_escape_newline_normalizer.sv
